### hdl/mmhpq_pkg.sv
// Shared types and codes for the max-min heap priority queue.
// No dependencies; used by the top level.
package mmhpq_pkg;

    localparam int KEY_W = 32;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DEL_MIN = 2'd1,
        CMD_DEL_MAX = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

### hdl/max_min_heap_priority_queue_unit.sv
// Max-min heap double-ended priority queue: sequencer, output register, heap RAM.
// Depends on mmhpq_pkg and mmhpq_ram.
//
// Channel  Dir  tdata (low bit first)                        tuser
// s_axis   in   value[31:0]                                  cmd[1:0]
// m_axis   out  min, max, removed (32 each), entries, pad     status[1:0]
//
// An insert takes longer for each grandparent swap, and a delete for each step of the trickle-down;
// a minimum delete with three or more keys first compares the two children of the root. All of
// this is set by the single read port of the heap RAM (one key a cycle).
// Reset is synchronous and empties the heap; the RAM contents are not cleared.
// A new command is taken while a result waits; the sequencer stalls only in its last state.
module max_min_heap_priority_queue_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // value
    input  logic [31:0]                            s_axis_tdata,
    // cmd
    input  logic [1:0]                             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // min_value, max_value, removed_value, entries, zero fill
    output logic [((3*32+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [1:0]                             m_axis_tuser
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY+1);
    localparam int XW  = CW + 2;
    localparam int KW  = mmhpq_pkg::KEY_W;
    localparam int ODW = ((3*32+CW+7)/8)*8;

    typedef enum logic [4:0] {
        S_IDLE, S_INS_RP, S_INS_CP, S_INS_W2, S_CL_R, S_CL_C,
        S_DM_R2, S_DM_R3, S_DM_C, S_DL_RP, S_DL_RL, S_DL_W,
        S_SK_RD, S_SK_CMP, S_SK_DEC, S_SK_WL, S_SK_GW, S_SK_GC, S_SK_GW2,
        S_FIN, S_F1, S_F2, S_F3, S_OUT
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_p, n_p;
    logic [CW-1:0]         r_best, n_best;
    logic [2:0]            r_ci, n_ci;
    logic                  r_gc, n_gc;
    logic                  r_dir, n_dir;
    logic                  r_max, n_max;
    logic signed [KW-1:0]  r_key, n_key;
    logic signed [KW-1:0]  r_bval, n_bval;
    logic signed [KW-1:0]  r_removed, n_removed;
    logic signed [KW-1:0]  r_min, n_min;
    logic signed [KW-1:0]  r_maxv, n_maxv;
    mmhpq_pkg::t_status    r_status, n_status;
    logic                  r_ovalid, n_ovalid;
    logic signed [KW-1:0]  r_o_min, n_o_min;
    logic signed [KW-1:0]  r_o_max, n_o_max;
    logic signed [KW-1:0]  r_o_rem, n_o_rem;
    logic [CW-1:0]         r_o_cnt, n_o_cnt;
    mmhpq_pkg::t_status    r_o_status, n_o_status;

    logic                  ram_we;
    logic [AW-1:0]         ram_wa;
    logic [KW-1:0]         ram_wd;
    logic [AW-1:0]         ram_ra;
    logic [KW-1:0]         ram_rdata;
    logic signed [KW-1:0]  rd;
    logic [XW-1:0]         xp;
    logic [XW-1:0]         cpos;
    logic                  cand_ok;
    logic                  s_acc;
    mmhpq_pkg::t_cmd       in_cmd;

    function automatic logic min_level(input logic [CW-1:0] p);
        logic lvl;
        lvl = 1'b0;
        for (int i = 0; i < CW; i++) begin
            if (p[i]) begin
                lvl = i[0];
            end
        end
        return lvl;
    endfunction

    mmhpq_ram #(
        .WIDTH(KW),
        .DEPTH(CAPACITY)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_raddr (ram_ra),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = mmhpq_pkg::t_cmd'(s_axis_tuser);
    assign rd            = $signed(ram_rdata);
    assign xp            = XW'(r_p);
    assign cand_ok       = (cpos <= XW'(r_cnt));

    always_comb begin
        case (r_ci)
            3'd0:    cpos = xp << 1;
            3'd1:    cpos = (xp << 1) + XW'(1);
            3'd2:    cpos = xp << 2;
            3'd3:    cpos = (xp << 2) + XW'(1);
            3'd4:    cpos = (xp << 2) + XW'(2);
            default: cpos = (xp << 2) + XW'(3);
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_p        = r_p;
        n_best     = r_best;
        n_ci       = r_ci;
        n_gc       = r_gc;
        n_dir      = r_dir;
        n_max      = r_max;
        n_key      = r_key;
        n_bval     = r_bval;
        n_removed  = r_removed;
        n_min      = r_min;
        n_maxv     = r_maxv;
        n_status   = r_status;
        n_ovalid   = r_ovalid;
        n_o_min    = r_o_min;
        n_o_max    = r_o_max;
        n_o_rem    = r_o_rem;
        n_o_cnt    = r_o_cnt;
        n_o_status = r_o_status;
        ram_we     = 1'b0;
        ram_wa     = '0;
        ram_wd     = '0;
        ram_ra     = '0;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_removed = '0;
                    n_status  = mmhpq_pkg::ST_DONE;
                    case (in_cmd)
                        mmhpq_pkg::CMD_INSERT: begin
                            if (r_cnt == CW'(CAPACITY)) begin
                                n_status = mmhpq_pkg::ST_FULL;
                                n_state  = S_FIN;
                            end else begin
                                ram_we  = 1'b1;
                                ram_wa  = AW'(r_cnt);
                                ram_wd  = s_axis_tdata;
                                n_cnt   = r_cnt + CW'(1);
                                n_p     = r_cnt + CW'(1);
                                n_key   = $signed(s_axis_tdata);
                                n_state = (r_cnt == '0) ? S_FIN : S_INS_RP;
                            end
                        end
                        mmhpq_pkg::CMD_DEL_MIN, mmhpq_pkg::CMD_DEL_MAX: begin
                            if (r_cnt == '0) begin
                                n_status = mmhpq_pkg::ST_EMPTY;
                                n_state  = S_FIN;
                            end else if (in_cmd == mmhpq_pkg::CMD_DEL_MAX ||
                                         r_cnt == CW'(1)) begin
                                n_p     = CW'(1);
                                n_max   = 1'b1;
                                n_state = S_DL_RP;
                            end else if (r_cnt == CW'(2)) begin
                                n_p     = CW'(2);
                                n_max   = 1'b0;
                                n_state = S_DL_RP;
                            end else begin
                                n_state = S_DM_R2;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_INS_RP: begin
                ram_ra  = AW'((r_p >> 1) - CW'(1));
                n_state = S_INS_CP;
            end
            S_INS_CP: begin
                if (min_level(r_p) ? (r_key > rd) : (r_key < rd)) begin
                    ram_we  = 1'b1;
                    ram_wa  = AW'(r_p - CW'(1));
                    ram_wd  = rd;
                    n_p     = r_p >> 1;
                    n_dir   = min_level(r_p);
                    n_state = S_INS_W2;
                end else begin
                    n_dir   = !min_level(r_p);
                    n_state = S_CL_R;
                end
            end
            S_INS_W2: begin
                ram_we  = 1'b1;
                ram_wa  = AW'(r_p - CW'(1));
                ram_wd  = r_key;
                n_state = S_CL_R;
            end
            S_CL_R: begin
                if (r_p < CW'(4)) begin
                    n_state = S_FIN;
                end else begin
                    ram_ra  = AW'((r_p >> 2) - CW'(1));
                    n_state = S_CL_C;
                end
            end
            S_CL_C: begin
                if (r_dir ? (r_key > rd) : (r_key < rd)) begin
                    ram_we  = 1'b1;
                    ram_wa  = AW'(r_p - CW'(1));
                    ram_wd  = rd;
                    n_p     = r_p >> 2;
                    n_state = S_INS_W2;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DM_R2: begin
                ram_ra  = AW'(1);
                n_state = S_DM_R3;
            end
            S_DM_R3: begin
                n_bval  = rd;
                ram_ra  = AW'(2);
                n_state = S_DM_C;
            end
            S_DM_C: begin
                n_p     = (rd < r_bval) ? CW'(3) : CW'(2);
                n_max   = 1'b0;
                n_state = S_DL_RP;
            end
            S_DL_RP: begin
                ram_ra  = AW'(r_p - CW'(1));
                n_state = S_DL_RL;
            end
            S_DL_RL: begin
                n_removed = rd;
                ram_ra    = AW'(r_cnt - CW'(1));
                n_state   = S_DL_W;
            end
            S_DL_W: begin
                ram_we  = 1'b1;
                ram_wa  = AW'(r_p - CW'(1));
                ram_wd  = rd;
                n_key   = rd;
                n_cnt   = r_cnt - CW'(1);
                n_ci    = 3'd0;
                n_state = (r_p <= r_cnt - CW'(1)) ? S_SK_RD : S_FIN;
            end
            S_SK_RD: begin
                if (r_ci == 3'd6 || !cand_ok) begin
                    n_state = (r_ci == 3'd0) ? S_FIN : S_SK_DEC;
                end else begin
                    ram_ra  = AW'(cpos - XW'(1));
                    n_state = S_SK_CMP;
                end
            end
            S_SK_CMP: begin
                if (r_ci == 3'd0 || (r_max ? (rd > r_bval) : (rd < r_bval))) begin
                    n_best = CW'(cpos);
                    n_bval = rd;
                    n_gc   = (r_ci >= 3'd2);
                end
                n_ci    = r_ci + 3'd1;
                n_state = S_SK_RD;
            end
            S_SK_DEC: begin
                if (r_max ? (r_bval > r_key) : (r_bval < r_key)) begin
                    ram_we  = 1'b1;
                    ram_wa  = AW'(r_p - CW'(1));
                    ram_wd  = r_bval;
                    n_state = r_gc ? S_SK_GW : S_SK_WL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SK_WL: begin
                ram_we  = 1'b1;
                ram_wa  = AW'(r_best - CW'(1));
                ram_wd  = r_key;
                n_state = S_FIN;
            end
            S_SK_GW: begin
                ram_we  = 1'b1;
                ram_wa  = AW'(r_best - CW'(1));
                ram_wd  = r_key;
                ram_ra  = AW'((r_best >> 1) - CW'(1));
                n_state = S_SK_GC;
            end
            S_SK_GC: begin
                n_p  = r_best;
                n_ci = 3'd0;
                if (r_max ? (r_key < rd) : (r_key > rd)) begin
                    ram_we  = 1'b1;
                    ram_wa  = AW'(r_best - CW'(1));
                    ram_wd  = rd;
                    n_bval  = rd;
                    n_state = S_SK_GW2;
                end else begin
                    n_state = S_SK_RD;
                end
            end
            S_SK_GW2: begin
                ram_we  = 1'b1;
                ram_wa  = AW'((r_best >> 1) - CW'(1));
                ram_wd  = r_key;
                n_key   = r_bval;
                n_state = S_SK_RD;
            end
            S_FIN: begin
                if (r_cnt == '0) begin
                    n_min   = '0;
                    n_maxv  = '0;
                    n_state = S_OUT;
                end else begin
                    ram_ra  = AW'(0);
                    n_state = S_F1;
                end
            end
            S_F1: begin
                n_maxv = rd;
                if (r_cnt == CW'(1)) begin
                    n_min   = rd;
                    n_state = S_OUT;
                end else begin
                    ram_ra  = AW'(1);
                    n_state = S_F2;
                end
            end
            S_F2: begin
                n_bval = rd;
                if (r_cnt == CW'(2)) begin
                    n_min   = rd;
                    n_state = S_OUT;
                end else begin
                    ram_ra  = AW'(2);
                    n_state = S_F3;
                end
            end
            S_F3: begin
                n_min   = (rd < r_bval) ? rd : r_bval;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid   = 1'b1;
                    n_o_min    = r_min;
                    n_o_max    = r_maxv;
                    n_o_rem    = r_removed;
                    n_o_cnt    = r_cnt;
                    n_o_status = r_status;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_p        <= n_p;
        r_best     <= n_best;
        r_ci       <= n_ci;
        r_gc       <= n_gc;
        r_dir      <= n_dir;
        r_max      <= n_max;
        r_key      <= n_key;
        r_bval     <= n_bval;
        r_removed  <= n_removed;
        r_min      <= n_min;
        r_maxv     <= n_maxv;
        r_status   <= n_status;
        r_o_min    <= n_o_min;
        r_o_max    <= n_o_max;
        r_o_rem    <= n_o_rem;
        r_o_cnt    <= n_o_cnt;
        r_o_status <= n_o_status;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = ODW'({r_o_cnt, r_o_rem, r_o_max, r_o_min});
    assign m_axis_tuser  = r_o_status;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("heap count beyond capacity");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ({1'b0, ram_wa} < (AW+1)'(r_cnt) + (AW+1)'(1)))
        else $error("heap write outside held keys");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_status == mmhpq_pkg::ST_FULL) |-> (r_o_cnt == CW'(CAPACITY)))
        else $error("full status with heap not full");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_status == mmhpq_pkg::ST_EMPTY) |->
        (r_o_cnt == '0 && r_o_rem == '0))
        else $error("empty status with keys or removed key");

    a_zero_extremes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_cnt == '0) |-> (r_o_min == '0 && r_o_max == '0))
        else $error("empty heap reports nonzero extremes");

endmodule

### hdl/mmhpq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module mmhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### test/tb.sv
// Testbench for max_min_heap_priority_queue_unit: random and directed commands
// checked against an in-bench max-min heap predictor. Depends on mmhpq_pkg and the DUT.
`timescale 1ns / 100ps

module tb;

    localparam int CAP = 64;
    localparam int DW = ((3*32+$clog2(CAP+1)+7)/8)*8;

    typedef struct packed {
        logic [31:0]        mn;
        logic [31:0]        mx;
        logic [31:0]        rm;
        logic [6:0]         cnt;
        mmhpq_pkg::t_status st;
    } t_result;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [DW-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;

    max_min_heap_priority_queue_unit #(.CAPACITY(CAP)) DUT (.*);

    logic signed [31:0] heap_keys [1:CAP];
    int key_count;
    t_result expected_q[$];
    int error_count = 0;
    int idle_pct = 29;
    int hold_cycles = 0;

    initial forever #6 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("max_min_heap_priority_queue_unit test failed");
        $finish;
    end

    function automatic bit is_min_level(int p);
        int lvl;
        lvl = 0;
        while (p > 1) begin
            p = p >> 1;
            lvl++;
        end
        return lvl[0];
    endfunction

    function automatic bit beats(int a, int b, bit want_max);
        return want_max ? (heap_keys[a] > heap_keys[b]) : (heap_keys[a] < heap_keys[b]);
    endfunction

    function automatic void swap_keys(int a, int b);
        logic signed [31:0] t;
        t = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = t;
    endfunction

    function automatic void climb(int p, bit want_max);
        while (p >= 4 && beats(p, p >> 2, want_max)) begin
            swap_keys(p, p >> 2);
            p = p >> 2;
        end
    endfunction

    function automatic void sink(int p, bit want_max);
        int best;
        int c;
        while (2*p <= key_count) begin
            best = 2*p;
            for (int k = 0; k < 5; k++) begin
                c = (k == 0) ? 2*p+1 : 4*p+k-1;
                if (c <= key_count && beats(c, best, want_max)) best = c;
            end
            if (best >= 4*p) begin
                if (!beats(best, p, want_max)) break;
                swap_keys(best, p);
                if (beats(best >> 1, best, want_max)) swap_keys(best, best >> 1);
                p = best;
            end else begin
                if (beats(best, p, want_max)) swap_keys(best, p);
                break;
            end
        end
    endfunction

    function automatic int min_slot();
        if (key_count == 1) return 1;
        if (key_count == 2) return 2;
        return (heap_keys[3] < heap_keys[2]) ? 3 : 2;
    endfunction

    function automatic logic [31:0] take_key(int p, bit want_max);
        logic [31:0] v;
        v = heap_keys[p];
        heap_keys[p] = heap_keys[key_count];
        key_count--;
        if (p <= key_count) sink(p, want_max);
        return v;
    endfunction

    function automatic t_result predict_heap(mmhpq_pkg::t_cmd cmd, logic [31:0] value);
        t_result r;
        int p;
        r = '0;
        r.st = mmhpq_pkg::ST_DONE;
        case (cmd)
            mmhpq_pkg::CMD_INSERT: begin
                if (key_count >= CAP) begin
                    r.st = mmhpq_pkg::ST_FULL;
                end else begin
                    key_count++;
                    p = key_count;
                    heap_keys[p] = value;
                    if (p > 1) begin
                        if (is_min_level(p)) begin
                            if (heap_keys[p] > heap_keys[p >> 1]) begin
                                swap_keys(p, p >> 1);
                                climb(p >> 1, 1);
                            end else begin
                                climb(p, 0);
                            end
                        end else begin
                            if (heap_keys[p] < heap_keys[p >> 1]) begin
                                swap_keys(p, p >> 1);
                                climb(p >> 1, 0);
                            end else begin
                                climb(p, 1);
                            end
                        end
                    end
                end
            end
            mmhpq_pkg::CMD_DEL_MIN, mmhpq_pkg::CMD_DEL_MAX: begin
                if (key_count == 0) begin
                    r.st = mmhpq_pkg::ST_EMPTY;
                end else if (cmd == mmhpq_pkg::CMD_DEL_MIN) begin
                    p = min_slot();
                    r.rm = take_key(p, !is_min_level(p));
                end else begin
                    r.rm = take_key(1, 1);
                end
            end
            default: ;
        endcase
        if (key_count > 0) begin
            r.mn = heap_keys[min_slot()];
            r.mx = heap_keys[1];
        end
        r.cnt = key_count[6:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic send_cmd(mmhpq_pkg::t_cmd cmd, logic [31:0] value);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_q.push_back(predict_heap(cmd, value));
    endtask

    task automatic finish_sends();
        s_axis_tvalid <= 0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        logic [6:0] got_cnt;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transfer", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = expected_q.pop_front();
                got_cnt = m_axis_tdata[96 +: 7];
                if (m_axis_tdata[31:0] !== want.mn)
                    report_mismatch("min", m_axis_tdata[31:0], want.mn);
                if (m_axis_tdata[63:32] !== want.mx)
                    report_mismatch("max", m_axis_tdata[63:32], want.mx);
                if (m_axis_tdata[95:64] !== want.rm)
                    report_mismatch("removed", m_axis_tdata[95:64], want.rm);
                if (got_cnt !== want.cnt)
                    report_mismatch("entries", 32'(got_cnt), 32'(want.cnt));
                if (m_axis_tuser !== want.st)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.st));
            end
        end
    end

    function automatic logic [31:0] rand_key();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_cmd(mmhpq_pkg::CMD_DEL_MIN, 0);
        send_cmd(mmhpq_pkg::CMD_DEL_MAX, 0);
        send_cmd(mmhpq_pkg::CMD_QUERY, 0);
        send_cmd(mmhpq_pkg::CMD_INSERT, 32'h7fff_ffff);
        send_cmd(mmhpq_pkg::CMD_DEL_MIN, 0);
        send_cmd(mmhpq_pkg::CMD_INSERT, 32'h8000_0000);
        send_cmd(mmhpq_pkg::CMD_INSERT, 32'h7fff_ffff);
        send_cmd(mmhpq_pkg::CMD_INSERT, 5);
        send_cmd(mmhpq_pkg::CMD_INSERT, 5);
        send_cmd(mmhpq_pkg::CMD_INSERT, 32'hffff_ffff);
        send_cmd(mmhpq_pkg::CMD_INSERT, 0);
        send_cmd(mmhpq_pkg::CMD_QUERY, 32'hffff_ffff);
        send_cmd(mmhpq_pkg::CMD_DEL_MAX, 0);
        send_cmd(mmhpq_pkg::CMD_DEL_MIN, 0);
        send_cmd(mmhpq_pkg::CMD_DEL_MIN, 0);
        send_cmd(mmhpq_pkg::CMD_DEL_MAX, 0);
        send_cmd(mmhpq_pkg::CMD_DEL_MIN, 0);
        send_cmd(mmhpq_pkg::CMD_DEL_MAX, 0);
        finish_sends();
    endtask

    task automatic test_fill_and_drain();
        for (int i = 0; i < CAP + 3; i++) send_cmd(mmhpq_pkg::CMD_INSERT, rand_key());
        for (int i = 0; i < CAP + 3; i++) begin
            if ($urandom_range(1) != 0) begin
                send_cmd(mmhpq_pkg::CMD_DEL_MIN, 0);
            end else begin
                send_cmd(mmhpq_pkg::CMD_DEL_MAX, 0);
            end
        end
        finish_sends();
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 30; i++) send_cmd(mmhpq_pkg::CMD_INSERT, $urandom);
        finish_sends();
    endtask

    task automatic test_random(int n, int bias);
        mmhpq_pkg::t_cmd c;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < bias) c = mmhpq_pkg::CMD_INSERT;
            else c = mmhpq_pkg::t_cmd'($urandom_range(3));
            send_cmd(c, rand_key());
        end
        finish_sends();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_fill_and_drain();
        test_backpressure();
        test_random(600, 50);
        idle_pct = 0;
        test_random(300, 40);
        idle_pct = 29;
        test_random(600, 10);
        test_random(200, 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("max_min_heap_priority_queue_unit test passed");
        end else begin
            $display("max_min_heap_priority_queue_unit test failed");
        end
        $finish;
    end
endmodule

### files.f
hdl/mmhpq_pkg.sv
hdl/mmhpq_ram.sv
hdl/max_min_heap_priority_queue_unit.sv
test/tb.sv
